>>> rtl/sfc_pkg.sv
// Shared types, constants and reset values of the sphere frustum cull block.
`default_nettype none

package sfc_pkg;

    // default geometry widths
    localparam int COORD_BITS_DEF = 21;
    localparam int DIR_BITS_DEF   = 16;

    // fixed register and format widths
    localparam int CAM_W      = 63;
    localparam int DIRREG_W   = 48;
    localparam int TAN_W      = 24;
    localparam int FAR_W      = 21;
    localparam int APB_DATA_W = 64;
    localparam int APB_ADDR_W = 6;
    localparam int OUT_DATA_W = 8;

    // fixed-point scaling shifts
    localparam int DIR_FRAC   = 14;   // Q.14 radius alignment for the behind test
    localparam int SIDE_SH    = 16;   // Q.18 offset to Q.34
    localparam int RAD_SH     = 30;   // Q.4 radius to Q.34

    // register reset values
    localparam logic [CAM_W-1:0]    CAM_POS_RST = 63'd2111062493102080;
    localparam logic [DIRREG_W-1:0] FRONT_RST   = 48'd211106232532992;
    localparam logic [DIRREG_W-1:0] UP_RST      = 48'd1073741824;
    localparam logic [DIRREG_W-1:0] RIGHT_RST   = 48'd16384;
    localparam logic [TAN_W-1:0]    TAN_V_RST   = 24'd27146;
    localparam logic [TAN_W-1:0]    TAN_H_RST   = 24'd48260;
    localparam logic [FAR_W-1:0]    FAR_RST     = 21'd160000;

    typedef enum logic [2:0] {
        REG_CAM_POS = 3'd0,
        REG_FRONT   = 3'd1,
        REG_UP      = 3'd2,
        REG_RIGHT   = 3'd3,
        REG_TAN_V   = 3'd4,
        REG_TAN_H   = 3'd5,
        REG_FAR     = 3'd6
    } reg_idx_t;

    typedef enum logic [2:0] {
        REASON_VISIBLE    = 3'd0,
        REASON_FAR        = 3'd1,
        REASON_BEHIND     = 3'd2,
        REASON_VERTICAL   = 3'd3,
        REASON_HORIZONTAL = 3'd4
    } reason_t;

endpackage

`default_nettype wire

>>> rtl/sphere_frustum_cull_core.sv
// Sphere versus view frustum cull: eight-stage pipeline with APB camera registers.
// Usage:
//   Slave stream (s_*) takes one sphere per request: center x,y,z signed Q17.4 and
//   an unsigned Q17.4 radius. Master stream (m_*) returns one result per sphere:
//   visible flag and reject reason (0 visible, 1 too far, 2 behind, 3 vertical,
//   4 horizontal), first failing test wins.
//   The APB port holds the camera: position, front/up/right vectors, the two
//   half-angle tangents and the far distance, 8 bytes apart. Write it only while
//   no sphere is in flight.
// Timing:
//   One sphere per cycle is taken while m_tready is high; the pipeline is 8 register
//   stages (difference, products, sums, magnitudes, tangent partial products, tangent
//   sum, extents, compare). The 40x24 tangent products are split in two halves
//   over two stages.
// Stall:
//   When m_tready is low the result holds in the output register; earlier
//   stages keep filling bubbles, then s_tready drops. Nothing is lost or repeated.
// Reset:
//   rst_n clears all valid bits and loads the default camera.
`default_nettype none

module sphere_frustum_cull_core
    import sfc_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int DIR_BITS   = DIR_BITS_DEF
)
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // center_x, center_y, center_z, sphere_radius from bit 0, zero padded
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [((4*COORD_BITS+7)/8)*8-1:0]  s_tdata,
    // visible, reject_reason from bit 0, zero padded
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [OUT_DATA_W-1:0]                   m_tdata,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [APB_ADDR_W-1:0]              paddr,
    input  wire logic [APB_DATA_W-1:0]              pwdata,
    output logic [APB_DATA_W-1:0]                   prdata,
    output logic                                    pready
);

    localparam int C    = COORD_BITS;
    localparam int D    = DIR_BITS;
    localparam int NST  = 8;
    localparam int DW   = C + 1;
    localparam int SQW  = 2 * DW;
    localparam int DSW  = SQW + 2;
    localparam int FSQW = 2 * C;
    localparam int PW   = DW + D;
    localparam int AW   = PW + 2;
    localparam int MW   = AW;
    localparam int LW   = (MW + 1) / 2;
    localparam int HW   = MW - LW;
    localparam int FW   = MW + TAN_W;
    localparam int RW   = C + RAD_SH;
    localparam int LHW  = MW + SIDE_SH;
    localparam int CW0  = (FW > RW) ? FW : RW;
    localparam int CW   = ((CW0 > LHW) ? CW0 : LHW) + 1;
    localparam int BH0  = C + DIR_FRAC + 1;
    localparam int BHW  = ((AW > BH0) ? AW : BH0) + 1;
    localparam int DEXT = (3 * D > DIRREG_W) ? 3 * D : DIRREG_W;

    // ---------------- configuration registers ----------------
    logic [CAM_W-1:0]    cam_reg;
    logic [DIRREG_W-1:0] front_reg;
    logic [DIRREG_W-1:0] up_reg;
    logic [DIRREG_W-1:0] right_reg;
    logic [TAN_W-1:0]    tanv_reg;
    logic [TAN_W-1:0]    tanh_reg;
    logic [FAR_W-1:0]    far_reg;
    logic [FSQW-1:0]     far_sq_reg;
    logic [FSQW-1:0]     far_sq_next;
    logic                cfg_wr;
    reg_idx_t            cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = reg_idx_t'(paddr[5:3]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cam_reg   <= CAM_POS_RST;
            front_reg <= FRONT_RST;
            up_reg    <= UP_RST;
            right_reg <= RIGHT_RST;
            tanv_reg  <= TAN_V_RST;
            tanh_reg  <= TAN_H_RST;
            far_reg   <= FAR_RST;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_CAM_POS: cam_reg   <= pwdata[CAM_W-1:0];
                REG_FRONT:   front_reg <= pwdata[DIRREG_W-1:0];
                REG_UP:      up_reg    <= pwdata[DIRREG_W-1:0];
                REG_RIGHT:   right_reg <= pwdata[DIRREG_W-1:0];
                REG_TAN_V:   tanv_reg  <= pwdata[TAN_W-1:0];
                REG_TAN_H:   tanh_reg  <= pwdata[TAN_W-1:0];
                REG_FAR:     far_reg   <= pwdata[FAR_W-1:0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_CAM_POS: prdata = APB_DATA_W'(cam_reg);
            REG_FRONT:   prdata = APB_DATA_W'(front_reg);
            REG_UP:      prdata = APB_DATA_W'(up_reg);
            REG_RIGHT:   prdata = APB_DATA_W'(right_reg);
            REG_TAN_V:   prdata = APB_DATA_W'(tanv_reg);
            REG_TAN_H:   prdata = APB_DATA_W'(tanh_reg);
            REG_FAR:     prdata = APB_DATA_W'(far_reg);
            default:     prdata = '0;
        endcase
    end

    // far distance squared is derived from the register, refreshed every cycle
    assign far_sq_next = FSQW'(far_reg[C-1:0]) * FSQW'(far_reg[C-1:0]);

    always_ff @(posedge clk)
    begin
        far_sq_reg <= far_sq_next;
    end

    logic [DEXT-1:0] front_x;
    logic [DEXT-1:0] up_x;
    logic [DEXT-1:0] right_x;

    assign front_x = DEXT'(front_reg);
    assign up_x    = DEXT'(up_reg);
    assign right_x = DEXT'(right_reg);

    // ---------------- pipeline control ----------------
    logic [NST-1:0] v_reg;
    logic [NST-1:0] v_next;
    logic [NST-1:0] en;

    always_comb
    begin
        en[NST-1] = !v_reg[NST-1] || m_tready;
        for (int i = NST - 2; i >= 0; i--)
        begin
            en[i] = !v_reg[i] || en[i+1];
        end
        v_next[0] = en[0] ? s_tvalid : v_reg[0];
        for (int i = 1; i < NST; i++)
        begin
            v_next[i] = en[i] ? v_reg[i-1] : v_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    assign s_tready = en[0];
    assign m_tvalid = v_reg[NST-1];

    // ---------------- stage 1: offset from camera ----------------
    logic signed [DW-1:0] d_next [3];
    logic signed [DW-1:0] d_reg  [3];
    logic [C-1:0]         rad1_reg;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            d_next[k] = DW'($signed(s_tdata[k*C +: C])) - DW'($signed(cam_reg[k*C +: C]));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            d_reg    <= d_next;
            rad1_reg <= s_tdata[3*C +: C];
        end
    end

    // ---------------- stage 2: squares and direction products ----------------
    logic signed [SQW-1:0] sq_next [3];
    logic signed [PW-1:0]  pf_next [3];
    logic signed [PW-1:0]  pu_next [3];
    logic signed [PW-1:0]  pr_next [3];
    logic signed [SQW-1:0] sq_reg  [3];
    logic signed [PW-1:0]  pf_reg  [3];
    logic signed [PW-1:0]  pu_reg  [3];
    logic signed [PW-1:0]  pr_reg  [3];
    logic [C-1:0]          rad2_reg;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            sq_next[k] = SQW'(d_reg[k]) * SQW'(d_reg[k]);
            pf_next[k] = PW'(d_reg[k]) * PW'($signed(front_x[k*D +: D]));
            pu_next[k] = PW'(d_reg[k]) * PW'($signed(up_x[k*D +: D]));
            pr_next[k] = PW'(d_reg[k]) * PW'($signed(right_x[k*D +: D]));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            sq_reg   <= sq_next;
            pf_reg   <= pf_next;
            pu_reg   <= pu_next;
            pr_reg   <= pr_next;
            rad2_reg <= rad1_reg;
        end
    end

    // ---------------- stage 3: dot products and far test ----------------
    logic [DSW-1:0]       dist_sq;
    logic                 far3_next;
    logic signed [AW-1:0] af_next;
    logic signed [AW-1:0] au_next;
    logic signed [AW-1:0] ar_next;
    logic                 far3_reg;
    logic signed [AW-1:0] af_reg;
    logic signed [AW-1:0] au_reg;
    logic signed [AW-1:0] ar_reg;
    logic [C-1:0]         rad3_reg;

    always_comb
    begin
        dist_sq   = DSW'(unsigned'(sq_reg[0])) + DSW'(unsigned'(sq_reg[1]))
                  + DSW'(unsigned'(sq_reg[2]));
        far3_next = dist_sq > DSW'(far_sq_reg);
        af_next   = AW'(pf_reg[0]) + AW'(pf_reg[1]) + AW'(pf_reg[2]);
        au_next   = AW'(pu_reg[0]) + AW'(pu_reg[1]) + AW'(pu_reg[2]);
        ar_next   = AW'(pr_reg[0]) + AW'(pr_reg[1]) + AW'(pr_reg[2]);
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            far3_reg <= far3_next;
            af_reg   <= af_next;
            au_reg   <= au_next;
            ar_reg   <= ar_next;
            rad3_reg <= rad2_reg;
        end
    end

    // ---------------- stage 4: behind test and magnitudes ----------------
    logic signed [BHW-1:0] bsum;
    logic                  behind4_next;
    logic [MW-1:0]         magf_next;
    logic [MW-1:0]         magu_next;
    logic [MW-1:0]         magr_next;
    logic                  far4_reg;
    logic                  behind4_reg;
    logic                  neg4_reg;
    logic [MW-1:0]         magf_reg;
    logic [MW-1:0]         magu4_reg;
    logic [MW-1:0]         magr4_reg;
    logic [C-1:0]          rad4_reg;

    always_comb
    begin
        bsum         = BHW'(af_reg) + $signed(BHW'(rad3_reg) << DIR_FRAC);
        behind4_next = bsum[BHW-1];
        magf_next    = af_reg[AW-1] ? MW'(~af_reg + 1'b1) : MW'(af_reg);
        magu_next    = au_reg[AW-1] ? MW'(~au_reg + 1'b1) : MW'(au_reg);
        magr_next    = ar_reg[AW-1] ? MW'(~ar_reg + 1'b1) : MW'(ar_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            far4_reg    <= far3_reg;
            behind4_reg <= behind4_next;
            neg4_reg    <= af_reg[AW-1];
            magf_reg    <= magf_next;
            magu4_reg   <= magu_next;
            magr4_reg   <= magr_next;
            rad4_reg    <= rad3_reg;
        end
    end

    // ---------------- stage 5: front times tangent, split in halves ----------------
    logic [LW+TAN_W-1:0] plo_v_next;
    logic [HW+TAN_W-1:0] phi_v_next;
    logic [LW+TAN_W-1:0] plo_h_next;
    logic [HW+TAN_W-1:0] phi_h_next;
    logic [LW+TAN_W-1:0] plo_v_reg;
    logic [HW+TAN_W-1:0] phi_v_reg;
    logic [LW+TAN_W-1:0] plo_h_reg;
    logic [HW+TAN_W-1:0] phi_h_reg;
    logic                far5_reg;
    logic                behind5_reg;
    logic                neg5_reg;
    logic [MW-1:0]       magu5_reg;
    logic [MW-1:0]       magr5_reg;
    logic [C-1:0]        rad5_reg;

    always_comb
    begin
        plo_v_next = (LW+TAN_W)'(magf_reg[LW-1:0]) * (LW+TAN_W)'(tanv_reg);
        phi_v_next = (HW+TAN_W)'(magf_reg[MW-1:LW]) * (HW+TAN_W)'(tanv_reg);
        plo_h_next = (LW+TAN_W)'(magf_reg[LW-1:0]) * (LW+TAN_W)'(tanh_reg);
        phi_h_next = (HW+TAN_W)'(magf_reg[MW-1:LW]) * (HW+TAN_W)'(tanh_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            plo_v_reg   <= plo_v_next;
            phi_v_reg   <= phi_v_next;
            plo_h_reg   <= plo_h_next;
            phi_h_reg   <= phi_h_next;
            far5_reg    <= far4_reg;
            behind5_reg <= behind4_reg;
            neg5_reg    <= neg4_reg;
            magu5_reg   <= magu4_reg;
            magr5_reg   <= magr4_reg;
            rad5_reg    <= rad4_reg;
        end
    end

    // ---------------- stage 6: join the partial products ----------------
    logic [FW-1:0] fv_next;
    logic [FW-1:0] fh_next;
    logic [FW-1:0] fv_reg;
    logic [FW-1:0] fh_reg;
    logic          far6_reg;
    logic          behind6_reg;
    logic          neg6_reg;
    logic [MW-1:0] magu6_reg;
    logic [MW-1:0] magr6_reg;
    logic [C-1:0]  rad6_reg;

    always_comb
    begin
        fv_next = (FW'(phi_v_reg) << LW) + FW'(plo_v_reg);
        fh_next = (FW'(phi_h_reg) << LW) + FW'(plo_h_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            fv_reg      <= fv_next;
            fh_reg      <= fh_next;
            far6_reg    <= far5_reg;
            behind6_reg <= behind5_reg;
            neg6_reg    <= neg5_reg;
            magu6_reg   <= magu5_reg;
            magr6_reg   <= magr5_reg;
            rad6_reg    <= rad5_reg;
        end
    end

    // ---------------- stage 7: extents in Q.34 ----------------
    logic [CW-1:0] rq;
    logic [CW-1:0] sum_v_next;
    logic [CW-1:0] sum_h_next;
    logic [CW:0]   diff_v_next;
    logic [CW:0]   diff_h_next;
    logic [CW-1:0] lhs_u_next;
    logic [CW-1:0] lhs_r_next;
    logic [CW-1:0] sum_v_reg;
    logic [CW-1:0] sum_h_reg;
    logic [CW:0]   diff_v_reg;
    logic [CW:0]   diff_h_reg;
    logic [CW-1:0] lhs_u_reg;
    logic [CW-1:0] lhs_r_reg;
    logic          far7_reg;
    logic          behind7_reg;
    logic          neg7_reg;

    always_comb
    begin
        rq          = CW'(rad6_reg) << RAD_SH;
        sum_v_next  = CW'(fv_reg) + rq;
        sum_h_next  = CW'(fh_reg) + rq;
        // top bit set means the tangent extent exceeds the radius
        diff_v_next = (CW+1)'(rq) - (CW+1)'(fv_reg);
        diff_h_next = (CW+1)'(rq) - (CW+1)'(fh_reg);
        lhs_u_next  = CW'(magu6_reg) << SIDE_SH;
        lhs_r_next  = CW'(magr6_reg) << SIDE_SH;
    end

    always_ff @(posedge clk)
    begin
        if (en[6])
        begin
            sum_v_reg   <= sum_v_next;
            sum_h_reg   <= sum_h_next;
            diff_v_reg  <= diff_v_next;
            diff_h_reg  <= diff_h_next;
            lhs_u_reg   <= lhs_u_next;
            lhs_r_reg   <= lhs_r_next;
            far7_reg    <= far6_reg;
            behind7_reg <= behind6_reg;
            neg7_reg    <= neg6_reg;
        end
    end

    // ---------------- stage 8: side tests and reason ----------------
    logic    out_v;
    logic    out_h;
    reason_t reason_next;
    logic    visible_next;
    reason_t reason_reg;
    logic    visible_reg;

    always_comb
    begin
        if (neg7_reg)
        begin
            out_v = diff_v_reg[CW] || (lhs_u_reg > diff_v_reg[CW-1:0]);
            out_h = diff_h_reg[CW] || (lhs_r_reg > diff_h_reg[CW-1:0]);
        end
        else
        begin
            out_v = lhs_u_reg > sum_v_reg;
            out_h = lhs_r_reg > sum_h_reg;
        end

        if (far7_reg)
        begin
            reason_next = REASON_FAR;
        end
        else if (behind7_reg)
        begin
            reason_next = REASON_BEHIND;
        end
        else if (out_v)
        begin
            reason_next = REASON_VERTICAL;
        end
        else if (out_h)
        begin
            reason_next = REASON_HORIZONTAL;
        end
        else
        begin
            reason_next = REASON_VISIBLE;
        end
        visible_next = (reason_next == REASON_VISIBLE);
    end

    always_ff @(posedge clk)
    begin
        if (en[7])
        begin
            reason_reg  <= reason_next;
            visible_reg <= visible_next;
        end
    end

    assign m_tdata = {(OUT_DATA_W-4)'(0), reason_reg, visible_reg};

endmodule

`default_nettype wire

>>> rtl/sfc_checker.sv
// Port-level checks of the sphere frustum cull core, bound to its top level.
`default_nettype none

module sfc_checker
    import sfc_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  s_tvalid,
    input wire logic                  s_tready,
    input wire logic                  m_tvalid,
    input wire logic                  m_tready,
    input wire logic [OUT_DATA_W-1:0] m_tdata,
    input wire logic                  pready
);

    // hold a stalled result
    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_visible_match: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[0] == (m_tdata[3:1] == REASON_VISIBLE)))
        else $error("visible flag disagrees with reject reason");

    a_reason_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[3:1] == REASON_VISIBLE || m_tdata[3:1] == REASON_FAR
                   || m_tdata[3:1] == REASON_BEHIND || m_tdata[3:1] == REASON_VERTICAL
                   || m_tdata[3:1] == REASON_HORIZONTAL))
        else $error("reject reason out of range");

    // a free output side frees the whole pipeline
    a_ready_flow: assert property (@(posedge clk) disable iff (!rst_n)
        m_tready |-> s_tready && pready)
        else $error("input stalled while output is ready");

    // a reset seen at one edge leaves the output empty at the next
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind sphere_frustum_cull_core sfc_checker u_sfc_checker (.*);

`default_nettype wire
